FILE: sv/tape_machine_instruction_core_assert.svh
// Assertion macros for the tape machine instruction core.
`ifndef TAPE_MACHINE_INSTRUCTION_CORE_ASSERT_SVH
`define TAPE_MACHINE_INSTRUCTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TMIC_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("tmic assertion failed");
`define TMIC_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tmic assertion failed");
`else
`define TMIC_ASSERT_IMP(name, clk, rst_n, pre, post)
`define TMIC_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif
`endif

FILE: sv/tmic_pkg.sv
`timescale 1ns / 1ps
package tmic_pkg;

	localparam int IADDR_W   = 16;
	localparam int BYTE_W    = 8;
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 1;
	localparam int SKIP_W    = 16;
	localparam logic [SKIP_W-1:0] SKIP_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		CMD_INC    = 3'd0,
		CMD_DEC    = 3'd1,
		CMD_RIGHT  = 3'd2,
		CMD_LEFT   = 3'd3,
		CMD_OPEN   = 3'd4,
		CMD_CLOSE  = 3'd5,
		CMD_OUTPUT = 3'd6,
		CMD_INPUT  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOINPUT   = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_UNMATCHED = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [IADDR_W-1:0] addr;
		logic [IADDR_W-1:0] seq_addr;
		logic [BYTE_W-1:0]  in_byte;
		logic               eof;
	} item_t;

	function automatic logic [IADDR_W-1:0] addr_mask(input int bits);
		logic [IADDR_W-1:0] m;
		if (bits >= IADDR_W) begin
			m = '1;
		end else begin
			m = IADDR_W'((32'd1 << bits) - 32'd1);
		end
		return m;
	endfunction

	function automatic logic [IADDR_W-1:0] addr_inc(input logic [IADDR_W-1:0] a,
			input logic [IADDR_W-1:0] m);
		return (a + IADDR_W'(1)) & m;
	endfunction

endpackage

FILE: sv/tmic_front.sv
`timescale 1ns / 1ps
module tmic_front import tmic_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clearing,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 item_valid,
	input  logic                 item_ready,
	output item_t                item
);

	localparam logic [IADDR_W-1:0] ADDR_MASK = addr_mask(ADDR_BITS);

	item_t       entry_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;
	item_t       in_item;
	logic        push;
	logic        pop;

	always_comb begin
		in_item.cmd      = cmd_t'(s_axis_tuser[2:0]);
		in_item.eof      = s_axis_tuser[3];
		in_item.addr     = s_axis_tdata[15:0];
		in_item.in_byte  = s_axis_tdata[23:16];
		in_item.seq_addr = addr_inc(s_axis_tdata[15:0], ADDR_MASK);
	end

	assign s_axis_tready = (count_q != 2'd2) && !clearing;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign item_valid    = count_q != 2'd0;
	assign pop           = item_valid && item_ready;
	assign item          = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/tmic_exec.sv
`timescale 1ns / 1ps
module tmic_exec import tmic_pkg::*; #(
	parameter int CELL_COUNT = 4096,
	parameter int LOOP_DEPTH = 32,
	parameter int ADDR_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 clearing,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic [M_TUSER_W-1:0] m_axis_tuser
);

	localparam int PTR_W   = $clog2(CELL_COUNT);
	localparam int DEPTH_W = $clog2(LOOP_DEPTH + 1);
	localparam int SIDX_W  = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
	localparam logic [PTR_W-1:0]   LAST_CELL = PTR_W'(CELL_COUNT - 1);
	localparam logic [DEPTH_W-1:0] FULL      = DEPTH_W'(LOOP_DEPTH);
	localparam logic [IADDR_W-1:0] ADDR_MASK = addr_mask(ADDR_BITS);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_RUN   = 4'b0010,
		S_CELL  = 4'b0100,
		S_TOS   = 4'b1000
	} state_t;

	state_t               state_q;
	state_t               n_state;
	logic [PTR_W-1:0]     clr_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [PTR_W-1:0]     n_ptr;
	logic [BYTE_W-1:0]    cell_q;
	logic [BYTE_W-1:0]    n_cell;
	logic [IADDR_W-1:0]   tos_q;
	logic [IADDR_W-1:0]   n_tos;
	logic [DEPTH_W-1:0]   depth_q;
	logic [DEPTH_W-1:0]   n_depth;
	logic [DEPTH_W-1:0]   below_top;
	logic [SKIP_W-1:0]    skip_q;
	logic [SKIP_W-1:0]    n_skip;

	logic [BYTE_W-1:0]    tape_mem [CELL_COUNT];
	logic [BYTE_W-1:0]    tape_rd_q;
	logic                 tape_we;
	logic [PTR_W-1:0]     tape_waddr;
	logic [BYTE_W-1:0]    tape_wdata;
	logic                 tape_re;
	logic [PTR_W-1:0]     tape_raddr;

	logic [IADDR_W-1:0]   stk_mem [LOOP_DEPTH];
	logic [IADDR_W-1:0]   stk_rd_q;
	logic                 stk_we;
	logic [SIDX_W-1:0]    stk_waddr;
	logic                 stk_re;
	logic [SIDX_W-1:0]    stk_raddr;

	logic                 fire;
	status_t              n_status;
	logic [IADDR_W-1:0]   n_next;
	logic                 n_flag;
	logic [BYTE_W-1:0]    n_byte;

	logic                 ovalid_q;
	status_t              out_status_q;
	logic [IADDR_W-1:0]   out_next_q;
	logic                 out_flag_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_skip_q;

	assign clearing   = state_q == S_CLEAR;
	assign fire       = (state_q == S_RUN) && item_valid && (!ovalid_q || m_axis_tready);
	assign item_ready = fire;
	assign below_top  = depth_q - DEPTH_W'(2);

	always_comb begin
		n_state    = state_q;
		n_ptr      = ptr_q;
		n_cell     = cell_q;
		n_tos      = tos_q;
		n_depth    = depth_q;
		n_skip     = skip_q;
		n_status   = ST_OK;
		n_next     = item.seq_addr;
		n_flag     = 1'b0;
		n_byte     = '0;
		tape_we    = 1'b0;
		tape_waddr = ptr_q;
		tape_wdata = '0;
		tape_re    = 1'b0;
		tape_raddr = ptr_q;
		stk_we     = 1'b0;
		stk_waddr  = depth_q[SIDX_W-1:0];
		stk_re     = 1'b0;
		stk_raddr  = below_top[SIDX_W-1:0];
		case (state_q)
			S_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_q;
				if (clr_q == LAST_CELL) begin
					n_state = S_RUN;
				end
			end
			S_CELL: begin
				n_cell  = tape_rd_q;
				n_state = S_RUN;
			end
			S_TOS: begin
				n_tos   = stk_rd_q;
				n_state = S_RUN;
			end
			S_RUN: begin
				if (fire && skip_q != '0) begin
					if (item.cmd == CMD_OPEN && skip_q != SKIP_MAX) begin
						n_skip = skip_q + SKIP_W'(1);
					end else if (item.cmd == CMD_CLOSE) begin
						n_skip = skip_q - SKIP_W'(1);
					end
				end else if (fire) begin
					case (item.cmd)
						CMD_INC: begin
							n_cell     = cell_q + BYTE_W'(1);
							tape_we    = 1'b1;
							tape_wdata = n_cell;
						end
						CMD_DEC: begin
							n_cell     = cell_q - BYTE_W'(1);
							tape_we    = 1'b1;
							tape_wdata = n_cell;
						end
						CMD_RIGHT: begin
							n_ptr      = (ptr_q == LAST_CELL) ? '0 : ptr_q + PTR_W'(1);
							tape_re    = 1'b1;
							tape_raddr = n_ptr;
							n_state    = S_CELL;
						end
						CMD_LEFT: begin
							n_ptr      = (ptr_q == '0) ? LAST_CELL : ptr_q - PTR_W'(1);
							tape_re    = 1'b1;
							tape_raddr = n_ptr;
							n_state    = S_CELL;
						end
						CMD_OPEN: begin
							if (cell_q == '0) begin
								n_skip = SKIP_W'(1);
							end else if (depth_q >= FULL) begin
								n_status = ST_OVERFLOW;
							end else begin
								stk_we  = 1'b1;
								n_tos   = item.addr;
								n_depth = depth_q + DEPTH_W'(1);
							end
						end
						CMD_CLOSE: begin
							if (depth_q == '0) begin
								n_status = ST_UNMATCHED;
							end else if (cell_q == '0) begin
								n_depth = depth_q - DEPTH_W'(1);
								stk_re  = 1'b1;
								n_state = S_TOS;
							end else begin
								n_next = addr_inc(tos_q, ADDR_MASK);
							end
						end
						CMD_OUTPUT: begin
							n_flag = 1'b1;
							n_byte = cell_q;
						end
						CMD_INPUT: begin
							if (item.eof) begin
								n_status = ST_NOINPUT;
							end else begin
								n_cell     = item.in_byte;
								tape_we    = 1'b1;
								tape_wdata = item.in_byte;
							end
						end
						default: begin
							n_status = ST_OK;
						end
					endcase
				end
			end
			default: begin
				n_state = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_waddr] <= tape_wdata;
		end
		if (tape_re) begin
			tape_rd_q <= tape_mem[tape_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= item.addr;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			ptr_q    <= '0;
			cell_q   <= '0;
			depth_q  <= '0;
			skip_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= n_state;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + PTR_W'(1);
			end
			ptr_q   <= n_ptr;
			cell_q  <= n_cell;
			depth_q <= n_depth;
			skip_q  <= n_skip;
			if (fire) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= n_tos;
		if (fire) begin
			out_status_q <= n_status;
			out_next_q   <= n_next;
			out_flag_q   <= n_flag;
			out_byte_q   <= n_byte;
			out_skip_q   <= n_skip != '0;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, out_skip_q, out_byte_q, out_next_q, out_status_q};
	assign m_axis_tuser  = out_flag_q;

endmodule

FILE: sv/tape_machine_instruction_core.sv
`timescale 1ns / 1ps
// A beat is held in the front FIFO and then in the output register of tmic_exec.
// Throughput: one command per cycle while m_axis is not stalled; a pointer move, and a loop
// close that pops, add a wait state as the tape or loop stack memory read is registered.
// Reset: after arst_n releases, a clearing pass over all CELL_COUNT cells (4096 by
// default) zeroes the tape, and no input beat is taken until it ends.
`include "tape_machine_instruction_core_assert.svh"
module tape_machine_instruction_core import tmic_pkg::*; #(
	parameter int CELL_COUNT = 4096,
	parameter int LOOP_DEPTH = 32,
	parameter int ADDR_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// instr_addr[15:0], in_byte[23:16]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// func[2:0], in_eof[3]
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// status[1:0], next_addr[17:2], out_byte[25:18], skipping[26], zero[31:27]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// out_valid[0]
	output logic [M_TUSER_W-1:0] m_axis_tuser
);

	item_t item;
	logic  item_valid;
	logic  item_ready;
	logic  clearing;

	tmic_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.clearing     (clearing),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item)
	);

	tmic_exec #(
		.CELL_COUNT(CELL_COUNT),
		.LOOP_DEPTH(LOOP_DEPTH),
		.ADDR_BITS (ADDR_BITS)
	) u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.clearing     (clearing),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	`TMIC_ASSERT_IMP(a_no_take_in_clear, clk, arst_n, s_axis_tready, !clearing)
	`TMIC_ASSERT_NXT(a_clear_once, clk, arst_n, !clearing, !clearing)
	`TMIC_ASSERT_IMP(a_out_not_skip, clk, arst_n, m_axis_tvalid && m_axis_tuser[0],
		!m_axis_tdata[26])
	`TMIC_ASSERT_IMP(a_err_not_skip, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK),
		!m_axis_tdata[26])

endmodule

FILE: sim/tmic_result_checker.sv
`timescale 1ns / 1ps
module tmic_result_checker import tmic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic [M_TUSER_W-1:0] m_axis_tuser,
	input  logic                 flush,
	output int                   errors
);

	localparam int CELLS = 4096;
	localparam int LOOPS = 32;

	typedef struct {
		status_t            status;
		logic [IADDR_W-1:0] next_addr;
		logic               out_valid;
		logic [BYTE_W-1:0]  out_byte;
		logic               skipping;
	} outcome_t;

	outcome_t           outcome_q[$];
	logic [BYTE_W-1:0]  tape[CELLS];
	logic [11:0]        head;
	logic [IADDR_W-1:0] open_addr[LOOPS];
	int                 open_count;
	logic [SKIP_W-1:0]  skip_level;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	function automatic outcome_t execute(input cmd_t op, input logic [IADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] data, input logic eof);
		outcome_t r;
		r.status    = ST_OK;
		r.next_addr = addr + 16'd1;
		r.out_valid = 1'b0;
		r.out_byte  = '0;
		if (skip_level != '0) begin
			if (op == CMD_OPEN) begin
				if (skip_level != SKIP_MAX) begin
					skip_level++;
				end
			end else if (op == CMD_CLOSE) begin
				skip_level--;
			end
		end else begin
			case (op)
				CMD_INC: begin
					tape[head] = tape[head] + 8'd1;
				end
				CMD_DEC: begin
					tape[head] = tape[head] - 8'd1;
				end
				CMD_RIGHT: begin
					head = head + 12'd1;
				end
				CMD_LEFT: begin
					head = head - 12'd1;
				end
				CMD_OPEN: begin
					if (tape[head] == '0) begin
						skip_level = 16'd1;
					end else if (open_count >= LOOPS) begin
						r.status = ST_OVERFLOW;
					end else begin
						open_addr[open_count] = addr;
						open_count++;
					end
				end
				CMD_CLOSE: begin
					if (open_count == 0) begin
						r.status = ST_UNMATCHED;
					end else if (tape[head] == '0) begin
						open_count--;
					end else begin
						r.next_addr = open_addr[open_count-1] + 16'd1;
					end
				end
				CMD_OUTPUT: begin
					r.out_valid = 1'b1;
					r.out_byte  = tape[head];
				end
				CMD_INPUT: begin
					if (eof) begin
						r.status = ST_NOINPUT;
					end else begin
						tape[head] = data;
					end
				end
			endcase
		end
		r.skipping = (skip_level != '0);
		return r;
	endfunction

	always @(posedge clk) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				tape[i] = '0;
			end
			head       = '0;
			open_count = 0;
			skip_level = '0;
			outcome_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				outcome_q.push_back(execute(cmd_t'(s_axis_tuser[2:0]), s_axis_tdata[15:0],
						s_axis_tdata[23:16], s_axis_tuser[3]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("result beat with nothing pending", m_axis_tdata, '0);
				end else begin
					want = outcome_q.pop_front();
					if (m_axis_tdata[1:0] !== want.status) begin
						report_mismatch("status", m_axis_tdata[1:0], want.status);
					end
					if (m_axis_tdata[17:2] !== want.next_addr) begin
						report_mismatch("next_addr", m_axis_tdata[17:2], want.next_addr);
					end
					if (m_axis_tdata[25:18] !== want.out_byte) begin
						report_mismatch("out_byte", m_axis_tdata[25:18], want.out_byte);
					end
					if (m_axis_tdata[26] !== want.skipping) begin
						report_mismatch("skipping", m_axis_tdata[26], want.skipping);
					end
					if (m_axis_tdata[31:27] !== '0) begin
						report_mismatch("tdata padding", m_axis_tdata[31:27], '0);
					end
					if (m_axis_tuser[0] !== want.out_valid) begin
						report_mismatch("out_valid", m_axis_tuser[0], want.out_valid);
					end
				end
			end
			if (flush && outcome_q.size() != 0) begin
				report_mismatch("results never delivered", outcome_q.size(), '0);
				outcome_q.delete();
			end
		end
	end

endmodule

FILE: sim/tb_tape_machine_instruction_core.sv
`timescale 1ns / 1ps
module tb_tape_machine_instruction_core;
	import tmic_pkg::*;

	localparam int LOOP_DEPTH   = 32;
	localparam int RANDOM_ITEMS = 760;
	localparam int CYCLE_LIMIT  = 2000000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// instr_addr[15:0], in_byte[23:16]
	logic [S_TDATA_W-1:0] s_axis_tdata;
	// func[2:0], in_eof[3]
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// status[1:0], next_addr[17:2], out_byte[25:18], skipping[26], zero[31:27]
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// out_valid[0]
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic                 flush;
	int                   fail_count;

	int   sent_beats;
	int   got_beats;
	int   status_seen[4];
	bit   calm;
	logic last_skip;

	tape_machine_instruction_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	tmic_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.flush         (flush),
		.errors        (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic cmd_t data_op();
		cmd_t c;
		do begin
			c = cmd_t'($urandom_range(CMD_INC, CMD_INPUT));
		end while (c == CMD_OPEN || c == CMD_CLOSE);
		return c;
	endfunction

	initial begin
		int stall;
		stall         = 0;
		got_beats     = 0;
		last_skip     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got_beats++;
				last_skip = m_axis_tdata[26];
				status_seen[m_axis_tdata[1:0]]++;
			end
			if (stall > 0 && !calm) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				stall = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Leaves tvalid high so that a following beat can go out without a bubble.
	task automatic put_cmd(input cmd_t op, input logic [15:0] addr, input logic [7:0] data,
			input logic eof);
		int gap;
		gap = calm ? 0 : (($urandom_range(0, 2) == 0) ? gap_len() : 0);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {data, addr};
		s_axis_tuser  <= {eof, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent_beats++;
	endtask

	task automatic put_rand(input cmd_t op);
		put_cmd(op, 16'($urandom), 8'($urandom), $urandom_range(0, 5) == 0);
	endtask

	task automatic put_cell(input logic [7:0] value);
		put_cmd(CMD_INPUT, 16'($urandom), value, 1'b0);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (got_beats < sent_beats) @(posedge clk);
	endtask

	task automatic loop_body(input int level);
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			if (level < 3 && $urandom_range(0, 5) == 0) begin
				run_loop(level + 1);
			end else begin
				put_rand(data_op());
			end
		end
	endtask

	task automatic run_loop(input int level);
		int passes;
		passes = $urandom_range(1, 3);
		put_cell(8'($urandom_range(1, 255)));
		put_rand(CMD_OPEN);
		repeat (passes) begin
			loop_body(level);
			put_rand(CMD_CLOSE);
		end
		if ($urandom_range(0, 4) != 0) begin
			put_cell(8'h00);
			put_rand(CMD_CLOSE);
		end
	endtask

	task automatic skip_body(input int level);
		int n;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if (level < 4 && $urandom_range(0, 3) == 0) begin
				put_rand(CMD_OPEN);
				skip_body(level + 1);
				put_rand(CMD_CLOSE);
			end else begin
				put_rand(data_op());
			end
		end
	endtask

	task automatic run_skip();
		put_cell(8'h00);
		put_rand(CMD_OPEN);
		skip_body(0);
		put_rand(CMD_CLOSE);
	endtask

	task automatic run_nest(input int opens);
		put_cell(8'($urandom_range(1, 255)));
		repeat (opens) begin
			if ($urandom_range(0, 7) == 0) begin
				put_rand(CMD_OUTPUT);
			end
			put_rand(CMD_OPEN);
		end
		repeat (opens + 2) begin
			put_cell(8'h00);
			put_rand(CMD_CLOSE);
		end
	endtask

	task automatic run_walk();
		cmd_t dir;
		int   n;
		dir = ($urandom_range(0, 1) == 0) ? CMD_RIGHT : CMD_LEFT;
		n   = $urandom_range(1, 24);
		repeat (n) begin
			put_rand(dir);
			if ($urandom_range(0, 2) == 0) begin
				put_rand(($urandom_range(0, 1) == 0) ? CMD_INC : CMD_OUTPUT);
			end
		end
	endtask

	// Brings the core out of skip mode and pops a random part of the loop stack.
	task automatic settle_core();
		int guard;
		guard = 0;
		drain_results();
		while (last_skip && guard < 70000) begin
			put_rand(CMD_CLOSE);
			drain_results();
			guard++;
		end
		repeat ($urandom_range(4, LOOP_DEPTH + 2)) begin
			put_cell(8'h00);
			put_rand(CMD_CLOSE);
		end
	endtask

	initial begin
		int start;
		int frags;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		flush         = 1'b0;
		calm          = 1'b0;
		sent_beats    = 0;
		frags         = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		put_cmd(CMD_INC, 16'h0000, 8'h00, 1'b0);
		put_cmd(CMD_DEC, 16'h0001, 8'hFF, 1'b1);
		put_cmd(CMD_DEC, 16'h0002, 8'h00, 1'b0);
		put_cmd(CMD_INC, 16'h0003, 8'h00, 1'b0);
		put_cmd(CMD_LEFT, 16'h0004, 8'h00, 1'b0);
		put_cmd(CMD_INPUT, 16'h0005, 8'hA5, 1'b0);
		put_cmd(CMD_OUTPUT, 16'h0006, 8'h00, 1'b0);
		put_cmd(CMD_RIGHT, 16'h0007, 8'h00, 1'b0);
		put_cmd(CMD_OUTPUT, 16'h0008, 8'h00, 1'b0);
		put_cmd(CMD_INPUT, 16'h0009, 8'h5A, 1'b1);
		put_cmd(CMD_OUTPUT, 16'h000A, 8'h00, 1'b0);
		put_cmd(CMD_CLOSE, 16'h1234, 8'h00, 1'b0);
		put_cmd(CMD_INPUT, 16'h8000, 8'hFF, 1'b0);
		put_cmd(CMD_OPEN, 16'hFFFF, 8'h00, 1'b0);
		put_cmd(CMD_CLOSE, 16'h0100, 8'h00, 1'b0);
		put_cmd(CMD_INPUT, 16'h0101, 8'h00, 1'b0);
		put_cmd(CMD_CLOSE, 16'h0102, 8'h00, 1'b0);
		put_cmd(CMD_OPEN, 16'h0200, 8'h00, 1'b0);
		put_cmd(CMD_OPEN, 16'h0201, 8'h00, 1'b0);
		put_cmd(CMD_INC, 16'h0202, 8'h00, 1'b0);
		put_cmd(CMD_OUTPUT, 16'h0203, 8'h00, 1'b0);
		put_cmd(CMD_INPUT, 16'h0204, 8'h77, 1'b0);
		put_cmd(CMD_CLOSE, 16'h0205, 8'h00, 1'b0);
		put_cmd(CMD_CLOSE, 16'h0206, 8'h00, 1'b0);
		put_cmd(CMD_OUTPUT, 16'hFFFF, 8'h00, 1'b0);
		run_nest(LOOP_DEPTH + 4);
		settle_core();

		start = sent_beats;
		while (sent_beats - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				calm = !calm;
			end
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 6)) put_rand(cmd_t'($urandom_range(CMD_INC, CMD_INPUT)));
				end
				2, 3, 4: begin
					run_loop(0);
				end
				5, 6: begin
					run_skip();
				end
				7: begin
					run_nest($urandom_range(LOOP_DEPTH - 4, LOOP_DEPTH + 8));
				end
				default: begin
					run_walk();
				end
			endcase
			frags++;
			if (frags % 7 == 0) begin
				settle_core();
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		flush <= 1'b1;
		@(posedge clk);
		flush <= 1'b0;
		@(posedge clk);
		$display("Executed %0d commands over nested and skipped loops, stack overflow and walks; %0d results checked.",
				sent_beats, got_beats);
		$display("Status codes seen: ok %0d, no input %0d, stack overflow %0d, unmatched close %0d.",
				status_seen[ST_OK], status_seen[ST_NOINPUT], status_seen[ST_OVERFLOW],
				status_seen[ST_UNMATCHED]);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/tmic_pkg.sv
sv/tmic_front.sv
sv/tmic_exec.sv
sv/tape_machine_instruction_core.sv
sim/tmic_result_checker.sv
sim/tb_tape_machine_instruction_core.sv
